### hw/rtl/sld_pkg.sv
// Package for the string list deframer: field widths, result kinds,
// error causes, ASCII codes and parameter defaults.
// No dependencies.
`default_nettype none

package sld_pkg;

    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 6;
    localparam int KIND_W  = 2;
    localparam int CAUSE_W = 2;

    localparam int MAX_STRINGS_DEF = 32;
    localparam int LEN_BITS_DEF    = 16;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd3;

    localparam logic [CAUSE_W-1:0] CAUSE_NONE  = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_DIGIT = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_BOUND = 2'd2;

    localparam logic [BYTE_W-1:0] SEPARATOR  = 8'h2C;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

endpackage

`default_nettype wire

### hw/rtl/sld_ifs.sv
// Channel interfaces of the string list deframer: encoded input words and
// tagged result words, each with valid/ready handshake.
// Depends on sld_pkg.
`default_nettype none

interface sld_in_if;
    logic                        valid;
    logic                        ready;
    logic [sld_pkg::BYTE_W-1:0]  in_byte;
    logic                        frame_start;

    modport source (output valid, output in_byte, output frame_start, input ready);
    modport sink   (input valid, input in_byte, input frame_start, output ready);
endinterface

interface sld_out_if;
    logic                         valid;
    logic                         ready;
    logic [sld_pkg::BYTE_W-1:0]   out_byte;
    logic [sld_pkg::IDX_W-1:0]    string_index;
    logic [sld_pkg::KIND_W-1:0]   kind;
    logic                         string_end;
    logic                         frame_end;
    logic [sld_pkg::CAUSE_W-1:0]  error_cause;

    modport source (output valid, output out_byte, output string_index, output kind,
                    output string_end, output frame_end, output error_cause,
                    input ready);
    modport sink   (input valid, input out_byte, input string_index, input kind,
                    input string_end, input frame_end, input error_cause,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/sld_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sld_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/string_list_deframer.sv
// Deframer for length-prefixed string lists; one byte word in, tagged words out.
// A byte's own result is in the output register in the cycle after the byte is
// taken; each empty-string marker follows a length RAM read and check, waiting
// while the output is held. Throughput: one byte per cycle in a string while the
// output is free; at each string boundary the next length is read in ST_RD/ST_CHK.
// Reset clears the parser and output valid; the length RAM is not cleared.
`default_nettype none

module string_list_deframer #(
    parameter int MAX_STRINGS = sld_pkg::MAX_STRINGS_DEF,
    parameter int LEN_BITS    = sld_pkg::LEN_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sld_in_if.sink      frame,
    sld_out_if.source   result
);

    localparam int AW    = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1;
    localparam int IW    = sld_pkg::IDX_W;
    localparam int PW    = LEN_BITS + 4;
    localparam logic [LEN_BITS-1:0] LEN_MAX   = {LEN_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0] COUNT_MAX = LEN_BITS'(MAX_STRINGS);

    typedef enum logic [1:0] {ST_IN, ST_RD, ST_CHK} state_t;
    typedef enum logic [1:0] {PH_IDLE, PH_COUNT, PH_LENGTHS, PH_PAYLOAD} phase_t;

    state_t                         state_reg, state_next;
    phase_t                         phase_reg, phase_next;
    logic [IW-1:0]                  total_reg, total_next;
    logic [IW-1:0]                  cur_reg, cur_next;
    logic [LEN_BITS-1:0]            acc_reg, acc_next;
    logic                           seen_reg, seen_next;
    logic                           ovf_reg, ovf_next;
    logic [LEN_BITS-1:0]            left_reg, left_next;

    logic                           ovalid_reg, ovalid_next;
    logic [sld_pkg::BYTE_W-1:0]     obyte_reg, obyte_next;
    logic [IW-1:0]                  oidx_reg, oidx_next;
    logic [sld_pkg::KIND_W-1:0]     okind_reg, okind_next;
    logic                           osend_reg, osend_next;
    logic                           ofend_reg, ofend_next;
    logic [sld_pkg::CAUSE_W-1:0]    ocause_reg, ocause_next;

    logic                           ram_we;
    logic                           ram_re;
    logic [LEN_BITS-1:0]            ram_rdata;

    logic                           out_free;
    logic                           accept;

    assign out_free    = !ovalid_reg || result.ready;
    assign frame.ready = (state_reg == ST_IN) && out_free;
    assign accept      = frame.valid && frame.ready;

    sld_ram #(
        .WIDTH (LEN_BITS),
        .DEPTH (MAX_STRINGS)
    ) u_len_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (cur_reg[AW-1:0]),
        .wr_data (acc_reg),
        .rd_en   (ram_re),
        .rd_addr (cur_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        phase_t          ph_v;
        logic [IW-1:0]   total_v;
        logic [IW-1:0]   cur_v;
        logic            seen_v;
        logic            ovf_v;
        logic [LEN_BITS-1:0] acc_v;
        logic            last_v;
        logic            last_chk_v;
        logic            se_v;
        logic [PW-1:0]   prod_v;
        logic            fail_v;
        logic [sld_pkg::CAUSE_W-1:0] cause_v;

        state_next  = state_reg;
        phase_next  = phase_reg;
        total_next  = total_reg;
        cur_next    = cur_reg;
        acc_next    = acc_reg;
        seen_next   = seen_reg;
        ovf_next    = ovf_reg;
        left_next   = left_reg;
        ovalid_next = ovalid_reg && !result.ready;
        obyte_next  = obyte_reg;
        oidx_next   = oidx_reg;
        okind_next  = okind_reg;
        osend_next  = osend_reg;
        ofend_next  = ofend_reg;
        ocause_next = ocause_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        // A frame start restarts the parse and the byte is parsed as the start of the count.
        ph_v    = frame.frame_start ? PH_COUNT : phase_reg;
        total_v = frame.frame_start ? '0 : total_reg;
        cur_v   = frame.frame_start ? '0 : cur_reg;
        acc_v   = frame.frame_start ? '0 : acc_reg;
        seen_v  = frame.frame_start ? 1'b0 : seen_reg;
        ovf_v   = frame.frame_start ? 1'b0 : ovf_reg;
        last_v  = ({1'b0, cur_v} + (IW+1)'(1)) >= {1'b0, total_v};
        // The length lookup never takes a word, so it only looks at the registers.
        last_chk_v = ({1'b0, cur_reg} + (IW+1)'(1)) >= {1'b0, total_reg};
        se_v    = (left_reg == LEN_BITS'(1));
        prod_v  = (PW'(acc_v) << 3) + (PW'(acc_v) << 1) + PW'(frame.in_byte[3:0]);
        fail_v  = 1'b0;
        cause_v = sld_pkg::CAUSE_NONE;

        unique case (state_reg)
            ST_IN:
            begin
                if (accept)
                begin
                    phase_next = ph_v;
                    total_next = total_v;
                    cur_next   = cur_v;
                    acc_next   = acc_v;
                    seen_next  = seen_v;
                    ovf_next   = ovf_v;
                    if (frame.frame_start)
                    begin
                        left_next = '0;
                    end

                    if (ph_v == PH_PAYLOAD)
                    begin
                        left_next   = left_reg - LEN_BITS'(1);
                        ovalid_next = 1'b1;
                        obyte_next  = frame.in_byte;
                        oidx_next   = cur_v;
                        okind_next  = sld_pkg::KIND_PAYLOAD;
                        osend_next  = se_v;
                        ofend_next  = se_v && last_v;
                        ocause_next = sld_pkg::CAUSE_NONE;
                        if (se_v)
                        begin
                            cur_next = cur_v + IW'(1);
                            if (last_v)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                state_next = ST_RD;
                            end
                        end
                    end
                    else if (ph_v != PH_IDLE)
                    begin
                        if (frame.in_byte >= sld_pkg::ASCII_ZERO &&
                            frame.in_byte <= sld_pkg::ASCII_NINE)
                        begin
                            seen_next = 1'b1;
                            if (prod_v > PW'(LEN_MAX))
                            begin
                                acc_next = LEN_MAX;
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                acc_next = prod_v[LEN_BITS-1:0];
                            end
                        end
                        else if (frame.in_byte != sld_pkg::SEPARATOR || !seen_v)
                        begin
                            fail_v  = 1'b1;
                            cause_v = sld_pkg::CAUSE_DIGIT;
                        end
                        else if (ovf_v)
                        begin
                            fail_v  = 1'b1;
                            cause_v = sld_pkg::CAUSE_BOUND;
                        end
                        else if (ph_v == PH_COUNT)
                        begin
                            if (acc_v > COUNT_MAX)
                            begin
                                fail_v  = 1'b1;
                                cause_v = sld_pkg::CAUSE_BOUND;
                            end
                            else
                            begin
                                total_next = acc_v[IW-1:0];
                                acc_next   = '0;
                                seen_next  = 1'b0;
                                ovf_next   = 1'b0;
                                cur_next   = '0;
                                if (acc_v == '0)
                                begin
                                    ovalid_next = 1'b1;
                                    obyte_next  = '0;
                                    oidx_next   = '0;
                                    okind_next  = sld_pkg::KIND_NONE;
                                    osend_next  = 1'b0;
                                    ofend_next  = 1'b1;
                                    ocause_next = sld_pkg::CAUSE_NONE;
                                    phase_next  = PH_IDLE;
                                end
                                else
                                begin
                                    phase_next = PH_LENGTHS;
                                end
                            end
                        end
                        else
                        begin
                            // Length list: store this length, then move on.
                            ram_we    = 1'b1;
                            acc_next  = '0;
                            seen_next = 1'b0;
                            ovf_next  = 1'b0;
                            if (last_v)
                            begin
                                phase_next = PH_PAYLOAD;
                                cur_next   = '0;
                                state_next = ST_RD;
                            end
                            else
                            begin
                                cur_next = cur_v + IW'(1);
                            end
                        end

                        if (fail_v)
                        begin
                            ovalid_next = 1'b1;
                            obyte_next  = '0;
                            oidx_next   = cur_v;
                            okind_next  = sld_pkg::KIND_ERROR;
                            osend_next  = 1'b0;
                            ofend_next  = 1'b1;
                            ocause_next = cause_v;
                            phase_next  = PH_IDLE;
                        end
                    end
                end
            end

            ST_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_CHK;
            end

            ST_CHK:
            begin
                if (ram_rdata != '0)
                begin
                    left_next  = ram_rdata;
                    state_next = ST_IN;
                end
                else if (out_free)
                begin
                    // Zero-length string: emit its marker and look at the next one.
                    ovalid_next = 1'b1;
                    obyte_next  = '0;
                    oidx_next   = cur_reg;
                    okind_next  = sld_pkg::KIND_EMPTY;
                    osend_next  = 1'b1;
                    ofend_next  = last_chk_v;
                    ocause_next = sld_pkg::CAUSE_NONE;
                    cur_next    = cur_reg + IW'(1);
                    if (last_chk_v)
                    begin
                        phase_next = PH_IDLE;
                        state_next = ST_IN;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IN;
            phase_reg  <= PH_IDLE;
            total_reg  <= '0;
            cur_reg    <= '0;
            acc_reg    <= '0;
            seen_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
            left_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            total_reg  <= total_next;
            cur_reg    <= cur_next;
            acc_reg    <= acc_next;
            seen_reg   <= seen_next;
            ovf_reg    <= ovf_next;
            left_reg   <= left_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obyte_reg  <= obyte_next;
        oidx_reg   <= oidx_next;
        okind_reg  <= okind_next;
        osend_reg  <= osend_next;
        ofend_reg  <= ofend_next;
        ocause_reg <= ocause_next;
    end

    assign result.valid        = ovalid_reg;
    assign result.out_byte     = obyte_reg;
    assign result.string_index = oidx_reg;
    assign result.kind         = okind_reg;
    assign result.string_end   = osend_reg;
    assign result.frame_end    = ofend_reg;
    assign result.error_cause  = ocause_reg;

endmodule

`default_nettype wire
